// ----- src/lpfm_pkg.sv -----
// Shared types and constants of the lamp phase fault monitor.
// No dependencies; every other file of the block imports this package.
package lpfm_pkg;

	// Phase counts: lanes are built only for phases that are both configured and monitored
	localparam int unsigned PHASE_COUNT = 3;
	localparam int unsigned MONITORED   = 3;
	localparam int unsigned LIVE_PHASES = (PHASE_COUNT < MONITORED) ? PHASE_COUNT : MONITORED;

	// Stream widths: fields packed from bit 0 up, padded to whole bytes
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned PATTERN_W = 32;
	localparam int unsigned SENSOR_W  = 3;
	localparam int unsigned IN_W      = 72;
	localparam int unsigned OUT_W     = 48;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0]  REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0]  REG_BLIND      = 2'd1;
	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET = 16'd100;
	localparam logic [CFG_DATA_W-1:0] BLIND_RESET    = 16'd600;

	typedef enum logic [1:0] {
		HEALTH_OK    = 2'd0,
		HEALTH_OPEN  = 2'd1,
		HEALTH_BURNT = 2'd2
	} health_t;

	// Per-lane control from the poll front end
	typedef struct packed {
		logic                  take;
		logic                  changed;
		logic                  eval;
		logic                  on;
		logic                  active;
		logic [TIME_W-1:0]     now;
		logic [CFG_DATA_W-1:0] debounce;
	} lane_ctl_t;

	// Per-lane findings for one poll
	typedef struct packed {
		health_t health;
		logic    alert;
		logic    recover;
	} lane_res_t;

	// One merged result item
	typedef struct packed {
		logic [MONITORED-1:0]         recover;
		logic [MONITORED-1:0]         alert;
		health_t [MONITORED-1:0]      health;
		logic [PATTERN_W-1:0]         pattern;
		logic                         strobe;
	} result_t;

endpackage

// ----- src/lpfm_lane.sv -----
// One phase lane: classifies the sensor reading, debounces faults, latches health.
// Depends on lpfm_pkg.
module lpfm_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  lpfm_pkg::lane_ctl_t ctl,
	output lpfm_pkg::lane_res_t res
);
	import lpfm_pkg::*;

	logic              debouncing_q, debouncing_d;
	logic              alert_done_q, alert_done_d;
	health_t           health_q, health_d;
	logic [TIME_W-1:0] stamp_q;
	logic              stamp_load;
	logic              deb_eff;
	health_t           seen;
	logic [TIME_W-1:0] held;
	logic              expired;

	// Fault classification: on with the sensor active is open, off with the sensor inactive is burnt
	always_comb begin
		if (ctl.on && ctl.active)
			seen = HEALTH_OPEN;
		else if (!ctl.on && !ctl.active)
			seen = HEALTH_BURNT;
		else
			seen = HEALTH_OK;
	end

	assign held    = ctl.now - stamp_q;
	assign expired = held > {{(TIME_W-CFG_DATA_W){1'b0}}, ctl.debounce};
	assign deb_eff = ctl.changed ? 1'b0 : debouncing_q;

	// Next state and findings
	always_comb begin
		debouncing_d = deb_eff;
		alert_done_d = alert_done_q;
		health_d     = health_q;
		stamp_load   = 1'b0;
		res.alert    = 1'b0;
		res.recover  = 1'b0;
		if (ctl.eval) begin
			if (seen != HEALTH_OK) begin
				if (!deb_eff) begin
					debouncing_d = 1'b1;
					stamp_load   = 1'b1;
				end else if (expired) begin
					health_d = seen;
					if (!alert_done_q) begin
						res.alert    = 1'b1;
						alert_done_d = 1'b1;
					end
				end
			end else begin
				res.recover  = (health_q != HEALTH_OK);
				debouncing_d = 1'b0;
				health_d     = HEALTH_OK;
				alert_done_d = 1'b0;
			end
		end
		res.health = health_d;
	end

	// Lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debouncing_q <= 1'b0;
			alert_done_q <= 1'b0;
			health_q     <= HEALTH_OK;
		end else if (ctl.take) begin
			debouncing_q <= debouncing_d;
			alert_done_q <= alert_done_d;
			health_q     <= health_d;
		end
	end

	// Fault stamp, only read while debouncing is set
	always_ff @(posedge clk) begin
		if (ctl.take && stamp_load)
			stamp_q <= ctl.now;
	end

endmodule

// ----- src/lpfm_merge.sv -----
// Merge stage: gathers lane findings into one result and holds it in the output register.
// Depends on lpfm_pkg.
module lpfm_merge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic                        strobe,
	input  logic [lpfm_pkg::PATTERN_W-1:0] pattern,
	input  lpfm_pkg::lane_res_t         lanes [lpfm_pkg::MONITORED],
	output logic                        room,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output lpfm_pkg::result_t           result
);
	import lpfm_pkg::*;

	result_t merged;
	result_t result_q;
	logic    valid_q;

	// Combine lanes
	always_comb begin
		merged.strobe  = strobe;
		merged.pattern = pattern;
		for (int i = 0; i < MONITORED; i++) begin
			merged.health[i]  = lanes[i].health;
			merged.alert[i]   = lanes[i].alert;
			merged.recover[i] = lanes[i].recover;
		end
	end

	// Output register: refilled when empty or being drained
	assign room = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (room)
			valid_q <= take;
	end

	always_ff @(posedge clk) begin
		if (take)
			result_q <= merged;
	end

	assign m_tvalid = valid_q;
	assign result   = result_q;

endmodule

// ----- src/lamp_phase_fault_monitor_core.sv -----
// Lamp phase fault monitor top level: poll front end, phase lanes, merge/output stage.
// A result is registered and appears on the master side in the cycle after its poll.
// Throughput: one poll per cycle unless m_tready stalls; output refills as it drains.
// Reset (arst_n, async, active low) clears pattern, change stamp, lane state and
// the output valid, and restores debounce_ms = 100 and blind_ms = 600.
// Depends on lpfm_pkg, lpfm_lane and lpfm_merge.
module lamp_phase_fault_monitor_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata: time_ms[31:0], expected_pattern[63:32], sensor_pattern[66:64], zero pad
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lpfm_pkg::IN_W-1:0]       s_tdata,
	// m_tdata: drive_strobe[0], drive_pattern[32:1], health_phase_zero[34:33],
	// health_phase_one[36:35], health_phase_two[38:37], alert_mask[41:39],
	// recover_mask[44:42], zero pad
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lpfm_pkg::OUT_W-1:0]      m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lpfm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpfm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lpfm_pkg::*;

	logic [CFG_DATA_W-1:0] debounce_q, blind_q;
	logic [PATTERN_W-1:0]  last_pattern_q;
	logic [TIME_W-1:0]     change_stamp_q;
	logic [TIME_W-1:0]     now;
	logic [PATTERN_W-1:0]  pattern;
	logic [SENSOR_W-1:0]   sensed;
	logic [TIME_W-1:0]     elapsed;
	logic                  take, changed, eval;
	lane_ctl_t             ctl   [MONITORED];
	lane_res_t             lanes [MONITORED];
	result_t               result;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			blind_q    <= BLIND_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_BLIND:    blind_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Poll front end: change detection and blind window
	assign now     = s_tdata[TIME_W-1:0];
	assign pattern = s_tdata[TIME_W+PATTERN_W-1:TIME_W];
	assign sensed  = s_tdata[TIME_W+PATTERN_W+SENSOR_W-1:TIME_W+PATTERN_W];
	assign take    = s_tvalid && s_tready;
	assign changed = pattern != last_pattern_q;
	assign elapsed = now - change_stamp_q;
	assign eval    = changed ? (blind_q == '0)
	                         : (elapsed >= {{(TIME_W-CFG_DATA_W){1'b0}}, blind_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pattern_q <= '0;
			change_stamp_q <= '0;
		end else if (take) begin
			last_pattern_q <= pattern;
			if (changed)
				change_stamp_q <= now;
		end
	end

	// Phase lanes; phases beyond the live count stay ok
	for (genvar i = 0; i < MONITORED; i++) begin : g_lane
		always_comb begin
			ctl[i].take     = take;
			ctl[i].changed  = changed;
			ctl[i].eval     = eval;
			ctl[i].on       = pattern[i];
			ctl[i].active   = sensed[i];
			ctl[i].now      = now;
			ctl[i].debounce = debounce_q;
		end
		if (i < LIVE_PHASES) begin : g_live
			lpfm_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl[i]),
				.res    (lanes[i])
			);
		end else begin : g_idle
			always_comb begin
				lanes[i].health  = HEALTH_OK;
				lanes[i].alert   = 1'b0;
				lanes[i].recover = 1'b0;
			end
		end
	end

	// Merge and output register
	lpfm_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.strobe   (changed),
		.pattern  (pattern),
		.lanes    (lanes),
		.room     (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.result   (result)
	);

	assign m_tdata = {{(OUT_W-$bits(result_t)){1'b0}}, result};

`ifndef SYNTHESIS
	// A phase never alerts and recovers in the same result
	a_alert_recover_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((result.alert & result.recover) == '0))
		else $error("alert and recover on the same phase");

	// An alerting phase zero shows a fault health
	a_alert_health: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result.alert[0]) |-> (result.health[0] != HEALTH_OK))
		else $error("alert with ok health");

	// A recovering phase zero shows ok health
	a_recover_health: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result.recover[0]) |-> (result.health[0] == HEALTH_OK))
		else $error("recover with fault health");

	// A strobed result carries the pattern just latched
	a_strobe_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result.strobe) |-> (result.pattern == last_pattern_q))
		else $error("strobe pattern mismatch");
`endif

endmodule
